/* rtl/rcc_pkg.sv */
// Shared types, constants and weighting functions for the raised-cosine crossfade joiner.
package rcc_pkg;

  // Width of one PCM sample.
  localparam int SAMPLE_W = 16;

  // Unity gain in Q15, and the Q30 constants and Q45 rounding term used to build the weight table.
  localparam logic [15:0] FULL_WEIGHT = 16'd32768;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint ROUND_Q45 = 64'sd17592186044416;

  // Horner divisors (2k-1)*2k of the cosine series, for k = 1 to 8.
  localparam longint HORNER_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  // Flags that travel with one transaction from the control unit to the mixing stage.
  typedef struct packed {
    logic has_result;
    logic last;
    logic wr_en;
    logic mix;
    logic pass;
  } op_t;

  // Keep weight g = cos^2(u) in Q15 from the Q30 angle u; used at elaboration only.
  function automatic logic [15:0] cos2_q15(input longint u);
    longint u2;
    longint t;
    longint g;
    u2 = (u * u) >>> 30;
    t = ONE_Q30;
    for (int k = 8; k >= 1; k--) begin
      t = ONE_Q30 - (((u2 * t) >>> 30) / HORNER_DIV[k-1]);
      if (t < 0) t = 0;
      if (t > ONE_Q30) t = ONE_Q30;
    end
    g = (t * t + ROUND_Q45) >>> 45;
    return 16'(g);
  endfunction

  // Q15 weight times sample, divided by 32768 with truncation toward zero.
  function automatic logic signed [16:0] weigh(input logic [15:0] w,
                                               input logic signed [15:0] s);
    logic signed [16:0] ws;
    logic signed [32:0] prod;
    ws = {1'b0, w};
    prod = ws * s;
    if (prod[32]) prod = prod + 33'sd32767;
    return prod[31:15];
  endfunction

  // Saturate a sum of two weighted samples to the 16-bit range.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

/* rtl/rcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rcc_weight_rom.sv */
// Constant table of raised-cosine keep weights with a registered read.
module rcc_weight_rom #(
  parameter int OVERLAP = 160
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(OVERLAP)-1:0] rd_addr,
  output logic [15:0]                rd_data
);

  localparam int AW = $clog2(OVERLAP);
  localparam int DEPTH = 2 ** AW;

  logic [15:0] weight_tab [DEPTH];

  // Each entry is fixed at elaboration; entries past the overlap read as zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    localparam longint unsigned ANGLE = (64'(i) * rcc_pkg::PI_Q30) / (2 * OVERLAP);
    localparam logic [15:0] WEIGHT =
      (i < OVERLAP) ? rcc_pkg::cos2_q15(longint'(ANGLE)) : 16'd0;
    assign weight_tab[i] = WEIGHT;
  end

  // Registered lookup.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= weight_tab[rd_addr];
    end
  end

endmodule

/* rtl/rcc_ctrl.sv */
// Ring bookkeeping: decodes each transaction and tracks fill, oldest entry and segment position.
module rcc_ctrl #(
  parameter int OVERLAP = 160
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       action,
  input  logic                       seg_start,
  output rcc_pkg::op_t               op,
  output logic [$clog2(OVERLAP)-1:0] rd_addr,
  output logic [$clog2(OVERLAP)-1:0] wr_addr,
  output logic [$clog2(OVERLAP)-1:0] rom_addr
);

  localparam int AW = $clog2(OVERLAP);
  localparam int CW = $clog2(OVERLAP + 1);
  localparam int SW = CW + 1;

  logic [CW-1:0] fill_count;
  logic [AW-1:0] oldest_ptr;
  logic [CW-1:0] seg_pos;
  logic          first_segment;

  logic [CW-1:0] fill_count_next;
  logic [AW-1:0] oldest_ptr_next;
  logic [CW-1:0] seg_pos_next;
  logic          first_segment_next;

  logic          ring_empty;
  logic          ring_full;
  logic          seg_first;
  logic [CW-1:0] pos;
  logic          in_ovl;
  logic          do_mix;
  logic          do_push;
  logic [AW-1:0] oldest_inc;
  logic [AW-1:0] mix_addr;
  logic [AW-1:0] tail_addr;

  // Ring index of base plus offset, where the sum stays below twice the depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= SW'(OVERLAP)) sum = sum - SW'(OVERLAP);
    return sum[AW-1:0];
  endfunction

  // Decode of the incoming transaction against the current ring state.
  always_comb begin
    ring_empty = (fill_count == '0);
    ring_full  = (fill_count == CW'(OVERLAP));
    seg_first  = first_segment && !(seg_start && !ring_empty);
    pos        = seg_start ? '0 : seg_pos;
    in_ovl     = (pos < CW'(OVERLAP));
    do_mix     = !action && in_ovl && !seg_first && (pos < fill_count);
    do_push    = !action && !do_mix;
    oldest_inc = (oldest_ptr == AW'(OVERLAP - 1)) ? '0 : oldest_ptr + 1'b1;
    mix_addr   = ring_add(oldest_ptr, pos);
    tail_addr  = ring_add(oldest_ptr, fill_count);

    op.has_result = action ? !ring_empty : (do_push && ring_full);
    op.last       = action && (fill_count == CW'(1));
    op.wr_en      = !action;
    op.mix        = do_mix;
    op.pass       = !in_ovl;

    rd_addr  = do_mix ? mix_addr : oldest_ptr;
    wr_addr  = do_mix ? mix_addr : (ring_full ? oldest_ptr : tail_addr);
    rom_addr = pos[AW-1:0];
  end

  // Next ring state for an accepted transaction.
  always_comb begin
    fill_count_next    = fill_count;
    oldest_ptr_next    = oldest_ptr;
    seg_pos_next       = seg_pos;
    first_segment_next = first_segment;
    if (action) begin
      if (fill_count <= CW'(1)) begin
        // The ring runs empty: re-arm for a new stream.
        fill_count_next    = '0;
        oldest_ptr_next    = '0;
        seg_pos_next       = '0;
        first_segment_next = 1'b1;
      end else begin
        oldest_ptr_next = oldest_inc;
        fill_count_next = fill_count - 1'b1;
      end
    end else begin
      first_segment_next = seg_first;
      seg_pos_next       = in_ovl ? pos + 1'b1 : pos;
      if (do_push) begin
        if (ring_full) begin
          oldest_ptr_next = oldest_inc;
        end else begin
          fill_count_next = fill_count + 1'b1;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      oldest_ptr    <= '0;
      seg_pos       <= '0;
      first_segment <= 1'b1;
    end else if (accept) begin
      fill_count    <= fill_count_next;
      oldest_ptr    <= oldest_ptr_next;
      seg_pos       <= seg_pos_next;
      first_segment <= first_segment_next;
    end
  end

endmodule

/* rtl/rcc_mix.sv */
// Weighting and mixing datapath: fades the new sample and blends it into the buffered tail.
module rcc_mix (
  input  rcc_pkg::op_t       op,
  input  logic [15:0]        weight,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] tail,
  output logic signed [15:0] wr_data
);

  logic [15:0]        fade_w;
  logic signed [16:0] kept;
  logic signed [16:0] faded;
  logic signed [17:0] sum;

  // Pass-through samples use unity fade weight so they come out unchanged.
  always_comb begin
    fade_w  = op.pass ? rcc_pkg::FULL_WEIGHT : rcc_pkg::FULL_WEIGHT - weight;
    kept    = rcc_pkg::weigh(weight, tail);
    faded   = rcc_pkg::weigh(fade_w, sample);
    sum     = 18'(kept) + 18'(faded);
    wr_data = op.mix ? rcc_pkg::sat16(sum) : faded[15:0];
  end

endmodule

/* rtl/raised_cosine_crossfade_joiner.sv */
// Top level of the raised-cosine crossfade joiner.
//
// Joins audio segments with a raised-cosine crossfade of OVERLAP samples. Every output
// sample passes through a ring of OVERLAP entries, so outside a drain a result leaves only
// when a new sample pushes the oldest one out; the first OVERLAP samples of each later
// segment are blended into the buffered tail where it reaches and give no result. Drain
// transactions empty the ring one sample at a time, flag the final one with last, and
// re-arm the block for a new stream. The block takes one transaction per clock cycle,
// sustained, with no stall other than backpressure on the output. Each transaction goes
// through two stages: the first reads the ring memory and the weight table, the second
// weights, mixes and writes back through the ring's single write port, forwarding that
// write to a transaction that reads the same entry right after. A result is offered from
// the output register. The ring memory needs no clearing pass after reset.
module raised_cosine_crossfade_joiner #(
  parameter int OVERLAP = 160
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [15:0] sample,
  input  logic               seg_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               last
);

  localparam int AW = $clog2(OVERLAP);

  logic               accept;
  rcc_pkg::op_t       op;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rom_addr;

  logic               s1_valid;
  rcc_pkg::op_t       s1_op;
  logic [AW-1:0]      s1_wr_addr;
  logic signed [15:0] s1_sample;
  logic               s1_advance;
  logic [15:0]        weight;
  logic [15:0]        ram_rd_data;
  logic               byp_hit;
  logic signed [15:0] byp_data;
  logic signed [15:0] tail;
  logic signed [15:0] wr_data;
  logic               ram_wr_en;
  logic               out_load;

  // Handshake: stage one moves on unless its result finds the output register full and unread.
  assign s1_advance = s1_valid && (!s1_op.has_result || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;
  assign out_load   = s1_advance && s1_op.has_result;
  assign ram_wr_en  = s1_advance && s1_op.wr_en;

  rcc_ctrl #(
    .OVERLAP(OVERLAP)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .action   (action),
    .seg_start(seg_start),
    .op       (op),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .rom_addr (rom_addr)
  );

  rcc_weight_rom #(
    .OVERLAP(OVERLAP)
  ) u_weight_rom (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(rom_addr),
    .rd_data(weight)
  );

  rcc_ram #(
    .WIDTH(rcc_pkg::SAMPLE_W),
    .DEPTH(OVERLAP)
  ) u_ring (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(s1_wr_addr),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(ram_rd_data)
  );

  // The write of the previous transaction lands at the same edge as this read.
  assign tail = byp_hit ? byp_data : $signed(ram_rd_data);

  rcc_mix u_mix (
    .op     (s1_op),
    .weight (weight),
    .sample (s1_sample),
    .tail   (tail),
    .wr_data(wr_data)
  );

  // Stage one control and forwarding flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      byp_hit  <= ram_wr_en && (s1_wr_addr == rd_addr);
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= op;
      s1_wr_addr <= wr_addr;
      s1_sample  <= sample;
      byp_data   <= wr_data;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= tail;
      last       <= s1_op.last;
    end
  end

  // A stalled stage-one transaction is held, not dropped.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_wr_addr))
    else $error("stage one transaction lost while stalled");

  // Every accepted transaction occupies stage one in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction did not reach stage one");

  // The last flag only comes with a drain result, which never writes the ring.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_op.last |-> s1_op.has_result && !s1_op.wr_en)
    else $error("last flag on a transaction that is not a drain result");

  // A result loaded into the output register is offered in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("loaded result not offered");

endmodule

/* bench/testbench.sv */
// Testbench for the raised-cosine crossfade joiner: directed and random streams checked against a predictor.
module testbench;

  localparam int OVERLAP = 160;
  localparam int ITEMS_TOTAL = 1400;
  localparam int QUIET_FROM = 1150;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DIR_ROWS = 18;
  localparam longint ANGLE_PI_Q30 = 64'sd3373259426;
  localparam longint UNITY_Q30 = 64'sd1073741824;
  localparam longint UNITY_Q15 = 64'sd32768;

  typedef logic signed [rcc_pkg::SAMPLE_W-1:0] pcm_t;
  typedef enum bit {ACT_SAMPLE = 1'b0, ACT_DRAIN = 1'b1} act_e;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_VALUE} chk_e;

  typedef struct {
    act_e act;
    pcm_t pcm;
    bit   start;
    chk_e chk;
    pcm_t want;
    bit   want_last;
  } dir_row_t;

  typedef struct {
    pcm_t pcm;
    bit   last;
  } joined_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic action;
  pcm_t sample;
  logic seg_start;
  logic out_valid;
  logic out_ready;
  pcm_t sample_out;
  logic last;

  // Predictor state: a copy of the tail ring and the stream position.
  pcm_t   tail_mem [OVERLAP];
  int     tail_fill;
  int     tail_head;
  int     overlap_pos;
  bit     in_first_seg;
  longint keep_q15 [OVERLAP];

  joined_t  joined_q [$];
  dir_row_t dir_rows [DIR_ROWS];
  int       failures;
  int       items_sent;
  int       cycle_count;
  bit       gaps_on;
  bit       hold_req;

  raised_cosine_crossfade_joiner #(
    .OVERLAP(OVERLAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .sample(sample),
    .seg_start(seg_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .last(last)
  );

  // Clock with a period of 4 time units.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Keep weight cos^2 of the crossfade angle in Q15, from a Taylor series in Q30 integers.
  function automatic longint cos_sq_q15(int x);
    longint ang;
    longint ang2;
    longint c;
    longint dv;
    ang = (longint'(x) * ANGLE_PI_Q30) / longint'(2 * OVERLAP);
    ang2 = (ang * ang) >>> 30;
    c = UNITY_Q30;
    for (int k = 8; k >= 1; k--) begin
      dv = longint'((2 * k - 1) * (2 * k));
      c = UNITY_Q30 - ((ang2 * c) >>> 30) / dv;
      if (c < 0) c = 0;
      if (c > UNITY_Q30) c = UNITY_Q30;
    end
    return (c * c + (longint'(1) << 44)) >>> 45;
  endfunction

  // Weight times sample over 32768; longint division truncates toward zero.
  function automatic int scale_q15(longint w, int s);
    return int'((w * longint'(s)) / UNITY_Q15);
  endfunction

  function automatic pcm_t clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return pcm_t'(v);
  endfunction

  function void restart_stream();
    tail_fill = 0;
    tail_head = 0;
    overlap_pos = 0;
    in_first_seg = 1'b1;
  endfunction

  // Append to the tail ring; once it is full the oldest sample leaves as a result.
  function bit push_tail(pcm_t v, output pcm_t leaving);
    leaving = '0;
    if (tail_fill < OVERLAP) begin
      tail_mem[(tail_head + tail_fill) % OVERLAP] = v;
      tail_fill++;
      return 1'b0;
    end
    leaving = tail_mem[tail_head];
    tail_mem[tail_head] = v;
    tail_head = (tail_head + 1) % OVERLAP;
    return 1'b1;
  endfunction

  // Advance the predicted joiner by one transaction; returns 1 if it gives a result.
  function bit predict_join(act_e act, pcm_t s, bit start, output joined_t res);
    longint g;
    int     faded;
    int     idx;
    bit     got;
    pcm_t   leaving;
    got = 1'b0;
    res.pcm = '0;
    res.last = 1'b0;
    if (act == ACT_DRAIN) begin
      if (tail_fill != 0) begin
        res.pcm = tail_mem[tail_head];
        tail_head = (tail_head + 1) % OVERLAP;
        tail_fill--;
        res.last = (tail_fill == 0);
        got = 1'b1;
      end
      if (tail_fill == 0) restart_stream();
    end else begin
      if (start) begin
        if (in_first_seg && tail_fill > 0) in_first_seg = 1'b0;
        overlap_pos = 0;
      end
      if (overlap_pos >= OVERLAP) begin
        got = push_tail(s, leaving);
        res.pcm = leaving;
      end else begin
        g = keep_q15[overlap_pos];
        faded = scale_q15(UNITY_Q15 - g, s);
        if (!in_first_seg && overlap_pos < tail_fill) begin
          // Blend the new segment into the buffered tail in place.
          idx = (tail_head + overlap_pos) % OVERLAP;
          tail_mem[idx] = clip16(scale_q15(g, tail_mem[idx]) + faded);
        end else begin
          got = push_tail(pcm_t'(faded), leaving);
          res.pcm = leaving;
        end
        overlap_pos++;
      end
    end
    return got;
  endfunction

  // Random PCM value with the two extremes weighted up.
  function automatic pcm_t rand_pcm();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return pcm_t'($urandom);
    endcase
  endfunction

  // Offer one transaction, wait for its acceptance and record what it should produce.
  task automatic send_txn(act_e act, pcm_t s, bit start, chk_e chk, pcm_t want, bit want_last);
    joined_t res;
    bit      got;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    sample <= s;
    seg_start <= start;
    do @(posedge clk); while (!in_ready);
    got = predict_join(act, s, start, res);
    if (chk == CHK_VALUE) begin
      res.pcm = want;
      res.last = want_last;
      joined_q.push_back(res);
    end else if (chk == CHK_PREDICT && got) begin
      joined_q.push_back(res);
    end
    items_sent++;
    if (items_sent >= QUIET_FROM) gaps_on = 1'b0;
    @(negedge clk);
  endtask

  // One segment of audio, with a rare stray drain or stray segment start as noise.
  task automatic send_segment(int len, bit first_flag);
    bit start;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_txn(ACT_DRAIN, rand_pcm(), 1'($urandom_range(0, 1)), CHK_PREDICT, '0, 1'b0);
      end
      start = (i == 0) ? first_flag : ($urandom_range(0, 99) == 0);
      send_txn(ACT_SAMPLE, rand_pcm(), start, CHK_PREDICT, '0, 1'b0);
    end
  endtask

  // A whole stream: a first segment, one or two crossfaded segments, then the drain.
  task automatic run_stream(int first_len);
    int seg_len;
    int drains;
    seg_len = (first_len > 0) ? first_len : $urandom_range(OVERLAP, OVERLAP + 100);
    send_segment(seg_len, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 9) == 0) seg_len = $urandom_range(1, 60);
      else seg_len = $urandom_range(OVERLAP, OVERLAP + 80);
      send_segment(seg_len, 1'b1);
    end
    // Usually empty the ring fully, sometimes with one more drain on the empty ring,
    // and now and then stop part way so that the next stream starts on a leftover tail.
    drains = tail_fill + (($urandom_range(0, 3) == 0) ? 1 : 0);
    if (tail_fill > 1 && $urandom_range(0, 7) == 0) drains = $urandom_range(1, tail_fill - 1);
    repeat (drains) begin
      send_txn(ACT_DRAIN, rand_pcm(), 1'($urandom_range(0, 1)), CHK_PREDICT, '0, 1'b0);
    end
  endtask

  // Receiver: random short stalls, one long hold-off, none near the end.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    joined_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (joined_q.size() == 0) begin
        $error("unexpected result: sample_out=%0d last=%0b", sample_out, last);
        failures++;
      end else begin
        exp_r = joined_q.pop_front();
        if (sample_out !== exp_r.pcm) begin
          $error("sample_out: expected %0d, actual %0d", exp_r.pcm, sample_out);
          failures++;
        end
        if (last !== exp_r.last) begin
          $error("last: expected %0b, actual %0b", exp_r.last, last);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("raised_cosine_crossfade_joiner test failed");
    $finish;
  end

  // Main sequence: reset, directed table, random streams, then wait for the last results.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_SAMPLE;
    sample = '0;
    seg_start = 1'b0;
    failures = 0;
    items_sent = 0;
    gaps_on = 1'b1;
    hold_req = 1'b0;
    for (int x = 0; x < OVERLAP; x++) keep_q15[x] = cos_sq_q15(x);
    restart_stream();

    // A drain on an empty ring gives nothing; the very first faded-in sample is silent.
    dir_rows = '{
      '{ACT_DRAIN,  16'sh5a5a, 1'b1, CHK_NONE,    16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh7fff, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh8000, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'shffff, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh0000, 1'b1, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh7fff, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh8000, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh3039, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'sh8000, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh8000, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'sh7fff, 1'b1, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'sh0000, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'shffff, 1'b1, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'sh1234, 1'b0, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'sha5a5, 1'b0, CHK_NONE,    16'sd0, 1'b0},
      '{ACT_SAMPLE, 16'sh7fff, 1'b1, CHK_PREDICT, 16'sd0, 1'b0},
      '{ACT_DRAIN,  16'sh0000, 1'b0, CHK_VALUE,   16'sd0, 1'b1},
      '{ACT_DRAIN,  16'sh7fff, 1'b1, CHK_NONE,    16'sd0, 1'b0}
    };

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_txn(dir_rows[i].act, dir_rows[i].pcm, dir_rows[i].start, dir_rows[i].chk,
               dir_rows[i].want, dir_rows[i].want_last);
    end

    // The first random stream runs under a long receiver hold-off so the block backs up.
    hold_req = 1'b1;
    run_stream(300);
    while (items_sent < ITEMS_TOTAL) run_stream(0);
    in_valid <= 1'b0;

    while (joined_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("raised_cosine_crossfade_joiner test passed");
    end else begin
      $display("raised_cosine_crossfade_joiner test failed");
    end
    $finish;
  end

endmodule
